// ===== design/ocgr_pkg.sv =====
// shared types and constants for the occupancy grid ray update unit
`default_nettype none
package ocgr_pkg;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
	localparam logic [1:0] CELL_FREE     = 2'd1;
	localparam logic [1:0] CELL_FRONTIER = 2'd2;
	localparam logic [1:0] CELL_OCCUPIED = 2'd3;

	localparam int CELL_W  = 2;
	localparam int POS_W   = 8;
	localparam int DIST_W  = 8;
	localparam int STEP_W  = DIST_W + 1;
	localparam int COORD_W = 10;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic signed [1:0] NB_DX [4] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};
	localparam logic signed [1:0] NB_DY [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_RESP   = 5'b01000,
		ST_SPARE  = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		PH_ROBOT = 5'b00001,
		PH_FWD   = 5'b00010,
		PH_BWD   = 5'b00100,
		PH_ENDF  = 5'b01000,
		PH_ENDB  = 5'b10000
	} phase_t;

endpackage
`default_nettype wire

// ===== design/occupancy_grid_ray_update_unit.sv =====
// top level of the occupancy grid ray update unit
// The map is GRID_SIDE x GRID_SIDE cells of 2 bits (0 unknown, 1 free, 2 frontier,
// 3 occupied) held in one ram with one write and one read port. Requests are taken
// one at a time. An update works on the robot cell and on each ray cell inside the
// map with one free write plus four neighbor read-modify-writes sharing the ram
// ports, then makes a stop check where each ray ends and writes each end cell.
// A read's result sits in an output register while further requests are taken.
// A clear, and the clearing pass after reset, write one cell per cycle over all
// GRID_SIDE * GRID_SIDE cells, during which no request is taken.
`default_nettype none
module occupancy_grid_ray_update_unit
	import ocgr_pkg::*;
#(
	parameter int GRID_SIDE = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// pos_x[7:0], pos_y[15:8], horizontal[16], dist_forward[24:17], dist_backward[32:25]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// cell_state[1:0]
	output logic      [M_DATA_W-1:0] m_tdata
);

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int AW = $clog2(CELLS);

	state_t state_q;
	phase_t phase_q;
	logic [2:0]        sub_q;
	logic [STEP_W-1:0] d_q;
	logic [AW-1:0]     clr_q;
	logic              rd_on_q;
	logic              m_tvalid_q;
	logic [CELL_W-1:0] m_data_q;

	logic [POS_W-1:0]  px_q, py_q;
	logic              horiz_q;
	logic [DIST_W-1:0] fwd_q, bwd_q;

	logic [AW-1:0] nb_addr_s1;
	logic          nb_ok_s1;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	logic          accept;
	coord_t        off, cx, cy, nx, ny;
	logic          cur_ok, nb_ok, ray_phase, ray_done;
	logic [AW-1:0] cur_addr, nb_addr;
	logic [DIST_W-1:0] ray_len;

	function automatic logic on_map(input coord_t x, input coord_t y);
		on_map = !x[COORD_W-1] && (x < coord_t'(GRID_SIDE))
			&& !y[COORD_W-1] && (y < coord_t'(GRID_SIDE));
	endfunction

	function automatic logic [AW-1:0] cell_addr(input coord_t x, input coord_t y);
		logic [AW-1:0] xa, ya;
		xa = AW'(x[POS_W-1:0]);
		ya = AW'(y[POS_W-1:0]);
		cell_addr = AW'(ya * AW'(GRID_SIDE)) + xa;
	endfunction

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_DATA_W-CELL_W){1'b0}}, m_data_q};

	// current cell and neighbor under work
	always_comb begin
		case (phase_q)
			PH_ROBOT: off = '0;
			PH_FWD, PH_ENDF: off = $signed({1'b0, d_q});
			PH_BWD, PH_ENDB: off = -$signed({1'b0, d_q});
			default: off = '0;
		endcase
		cx = $signed({2'b00, px_q}) + (horiz_q ? off : coord_t'(0));
		cy = $signed({2'b00, py_q}) + (horiz_q ? coord_t'(0) : off);
		nx = cx + coord_t'(NB_DX[sub_q[1:0]]);
		ny = cy + coord_t'(NB_DY[sub_q[1:0]]);
		cur_ok = on_map(cx, cy);
		nb_ok = on_map(nx, ny);
		cur_addr = cell_addr(cx, cy);
		nb_addr = cell_addr(nx, ny);
		ray_phase = (phase_q == PH_FWD) || (phase_q == PH_BWD);
		ray_len = (phase_q == PH_FWD) ? fwd_q : bwd_q;
		ray_done = ray_phase && ((d_q > {1'b0, ray_len}) || !cur_ok);
	end

	// ram port steering
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = CELL_UNKNOWN;
		ram_re = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				ram_raddr = cell_addr($signed({2'b00, s_tdata[7:0]}),
					$signed({2'b00, s_tdata[15:8]}));
				ram_re = accept && (s_tuser == CMD_READ)
					&& (s_tdata[7:0] < POS_W'(GRID_SIDE - 1) + 1'b1 || GRID_SIDE > 255)
					&& (s_tdata[15:8] < POS_W'(GRID_SIDE - 1) + 1'b1 || GRID_SIDE > 255);
			end
			ST_UPDATE: begin
				if (sub_q == 3'd0) begin
					ram_waddr = cur_addr;
					if ((phase_q == PH_ENDF) || (phase_q == PH_ENDB)) begin
						ram_we = cur_ok;
						ram_wdata = CELL_OCCUPIED;
					end else if (!ray_done) begin
						ram_we = cur_ok;
						ram_wdata = CELL_FREE;
						ram_re = nb_ok;
						ram_raddr = nb_addr;
					end
				end else begin
					ram_waddr = nb_addr_s1;
					ram_wdata = CELL_FRONTIER;
					ram_we = nb_ok_s1 && (ram_rdata == CELL_UNKNOWN);
					ram_re = (sub_q != 3'd4) && nb_ok;
					ram_raddr = nb_addr;
				end
			end
			default: begin
			end
		endcase
	end

	ocgr_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_grid (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= s_tdata[7:0];
			py_q <= s_tdata[15:8];
			horiz_q <= s_tdata[16];
			fwd_q <= s_tdata[24:17];
			bwd_q <= s_tdata[32:25];
		end
		nb_addr_s1 <= nb_addr;
		if (state_q == ST_RESP && (!m_tvalid_q || m_tready)) begin
			m_data_q <= rd_on_q ? ram_rdata : CELL_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_ROBOT;
			sub_q <= '0;
			d_q <= '0;
			clr_q <= '0;
			rd_on_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			nb_ok_s1 <= 1'b0;
		end else begin
			nb_ok_s1 <= (state_q == ST_UPDATE) && ram_re;
			if (state_q == ST_RESP && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_UPDATE: begin
								state_q <= ST_UPDATE;
								phase_q <= PH_ROBOT;
								sub_q <= '0;
								d_q <= '0;
							end
							CMD_READ: begin
								state_q <= ST_RESP;
								rd_on_q <= ram_re;
							end
							CMD_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_UPDATE: begin
					case (sub_q)
						3'd0: begin
							case (phase_q)
								PH_ENDF: begin
									phase_q <= PH_ENDB;
									d_q <= {1'b0, bwd_q} + 1'b1;
								end
								PH_ENDB: state_q <= ST_IDLE;
								PH_FWD: begin
									if (ray_done) begin
										phase_q <= PH_BWD;
										d_q <= STEP_W'(1);
									end else begin
										sub_q <= 3'd1;
									end
								end
								PH_BWD: begin
									if (ray_done) begin
										phase_q <= PH_ENDF;
										d_q <= {1'b0, fwd_q} + 1'b1;
									end else begin
										sub_q <= 3'd1;
									end
								end
								default: sub_q <= 3'd1;
							endcase
						end
						3'd4: begin
							sub_q <= '0;
							d_q <= d_q + 1'b1;
							if (phase_q == PH_ROBOT) begin
								phase_q <= PH_FWD;
							end
						end
						default: sub_q <= sub_q + 1'b1;
					endcase
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/ocgr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module ocgr_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/ocgr_checker.sv =====
// port-level checks for the occupancy grid ray update unit and their binding
`default_nettype none
module ocgr_checker
	import ocgr_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [1:0]          s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:CELL_W] == '0)
		else $error("result padding not zero");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == CMD_CLEAR |=> !s_tready ##1 !s_tready)
		else $error("request taken during clear");

	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == CMD_UPDATE |=> !s_tready ##1 !s_tready)
		else $error("request taken during update");

	a_read_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == CMD_READ && m_tvalid && !m_tready |=> !s_tready)
		else $error("request taken while read result pending");

endmodule

bind occupancy_grid_ray_update_unit ocgr_checker u_checker (.*);
`default_nettype wire

// ===== dv/tb_occupancy_grid_ray_update_unit.sv =====
// testbench for the occupancy grid ray update unit: map-tracking prediction and read checks
`timescale 1ns / 100ps
module tb_occupancy_grid_ray_update_unit;
	import ocgr_pkg::*;

	localparam int MAP_SIDE = 64;
	localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 4200;
	localparam int RANDOM_REQS = 205;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] px;
		logic [7:0] py;
		logic       horiz;
		logic [7:0] fwd;
		logic [7:0] bwd;
	} grid_req_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b1;
	logic [M_DATA_W-1:0] m_tdata;

	occupancy_grid_ray_update_unit #(
		.GRID_SIDE(MAP_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	logic [1:0] occ_map [0:MAP_CELLS-1];
	grid_req_t  req_queue[$];
	logic [1:0] cell_expect[$];
	grid_req_t  in_flight;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;
	int errors = 0;
	int n_update = 0;
	int n_read = 0;
	int n_clear = 0;
	int n_ignored = 0;
	int n_checked = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d requests and %0d reads outstanding",
			req_queue.size(), cell_expect.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit on_grid(int x, int y);
		return x >= 0 && x < MAP_SIDE && y >= 0 && y < MAP_SIDE;
	endfunction

	function automatic void mark_frontier(int x, int y);
		int nx, ny;
		for (int k = 0; k < 4; k++) begin
			nx = x + int'(NB_DX[k]);
			ny = y + int'(NB_DY[k]);
			if (on_grid(nx, ny) && occ_map[ny * MAP_SIDE + nx] == CELL_UNKNOWN)
				occ_map[ny * MAP_SIDE + nx] = CELL_FRONTIER;
		end
	endfunction

	function automatic void trace_ray(int px, int py, int sx, int sy, int len);
		int x, y;
		for (int d = 1; d <= len; d++) begin
			x = px + d * sx;
			y = py + d * sy;
			if (!on_grid(x, y))
				break;
			occ_map[y * MAP_SIDE + x] = CELL_FREE;
			mark_frontier(x, y);
		end
	endfunction

	function automatic void apply_scan(grid_req_t r);
		int px, py, sx, sy, fwd, bwd, ex, ey;
		px = int'(r.px);
		py = int'(r.py);
		fwd = int'(r.fwd);
		bwd = int'(r.bwd);
		sx = r.horiz ? 1 : 0;
		sy = r.horiz ? 0 : 1;
		if (on_grid(px, py))
			occ_map[py * MAP_SIDE + px] = CELL_FREE;
		mark_frontier(px, py);
		trace_ray(px, py, sx, sy, fwd);
		trace_ray(px, py, -sx, -sy, bwd);
		ex = px + (fwd + 1) * sx;
		ey = py + (fwd + 1) * sy;
		if (on_grid(ex, ey))
			occ_map[ey * MAP_SIDE + ex] = CELL_OCCUPIED;
		ex = px - (bwd + 1) * sx;
		ey = py - (bwd + 1) * sy;
		if (on_grid(ex, ey))
			occ_map[ey * MAP_SIDE + ex] = CELL_OCCUPIED;
	endfunction

	function automatic void apply_request(grid_req_t r);
		case (r.cmd)
			CMD_UPDATE: begin
				apply_scan(r);
				n_update++;
			end
			CMD_READ: begin
				if (on_grid(int'(r.px), int'(r.py)))
					cell_expect.push_back(occ_map[int'(r.py) * MAP_SIDE + int'(r.px)]);
				else
					cell_expect.push_back(CELL_UNKNOWN);
				n_read++;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < MAP_CELLS; i++)
					occ_map[i] = CELL_UNKNOWN;
				n_clear++;
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic grid_req_t make_req(logic [1:0] cmd, int x, int y, bit h, int f, int b);
		grid_req_t r;
		r.cmd = cmd;
		r.px = x[7:0];
		r.py = y[7:0];
		r.horiz = h;
		r.fwd = f[7:0];
		r.bwd = b[7:0];
		return r;
	endfunction

	function automatic int clip_byte(int v);
		return (v < 0) ? 0 : (v > 255) ? 255 : v;
	endfunction

	function automatic int pick_coord();
		int sel;
		sel = $urandom_range(99);
		if (sel < 80)
			return $urandom_range(MAP_SIDE - 1);
		else if (sel < 90)
			return $urandom_range(MAP_SIDE + 6, MAP_SIDE - 4);
		return $urandom_range(255);
	endfunction

	function automatic int pick_dist();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return $urandom_range(15);
		else if (sel < 90)
			return $urandom_range(70);
		return $urandom_range(255);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_request(in_flight);
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (req_queue.size() > 0) begin
				in_flight = req_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, in_flight.bwd, in_flight.fwd, in_flight.horiz,
					in_flight.py, in_flight.px};
				s_tuser <= in_flight.cmd;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and output stall pattern
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cell_expect.size() == 0) begin
				if (errors < 10)
					$display("%0t: cell state %0d with no read pending", $realtime, m_tdata[1:0]);
				errors++;
			end else begin
				if (m_tdata[1:0] !== cell_expect[0]) begin
					if (errors < 10)
						$display("%0t: cell_state expected %0d got %0d", $realtime,
							cell_expect[0], m_tdata[1:0]);
					errors++;
				end
				void'(cell_expect.pop_front());
				n_checked++;
			end
		end
		if (stall_timer == 0) begin
			stall_mode = $urandom_range(2);
			stall_timer = $urandom_range(16, 96);
		end else begin
			stall_timer--;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(1);
			default: m_tready <= ($urandom_range(3) == 0);
		endcase
	end

	initial begin
		int kind, lx, ly, x, y, cnt;
		bit lh;
		for (int i = 0; i < MAP_CELLS; i++)
			occ_map[i] = CELL_UNKNOWN;

		req_queue.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0));
		req_queue.push_back(make_req(CMD_UPDATE, 10, 10, 1, 5, 3));
		req_queue.push_back(make_req(CMD_READ, 16, 10, 0, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 6, 10, 1, 255, 255));
		req_queue.push_back(make_req(CMD_READ, 10, 11, 0, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 12, 10, 0, 0, 0));
		// full-length vertical rays clipped at both map edges
		req_queue.push_back(make_req(CMD_UPDATE, 63, 63, 0, 255, 255));
		req_queue.push_back(make_req(CMD_READ, 63, 0, 0, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 62, 30, 0, 0, 0));
		// robot far off the map, then just off with an in-map neighbor
		req_queue.push_back(make_req(CMD_UPDATE, 255, 255, 1, 0, 0));
		req_queue.push_back(make_req(CMD_UPDATE, 20, 64, 1, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 20, 63, 0, 0, 0));
		// ray starting just off the map stepping into it
		req_queue.push_back(make_req(CMD_UPDATE, 64, 20, 1, 0, 3));
		req_queue.push_back(make_req(CMD_READ, 61, 20, 0, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 60, 20, 0, 0, 0));
		// end cell written although its ray stopped at once
		req_queue.push_back(make_req(CMD_UPDATE, 70, 30, 1, 0, 15));
		req_queue.push_back(make_req(CMD_READ, 54, 30, 0, 0, 0));
		req_queue.push_back(make_req(CMD_UPDATE, 30, 40, 0, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 30, 41, 0, 0, 0));
		req_queue.push_back(make_req(CMD_UNUSED, 255, 255, 1, 255, 255));
		req_queue.push_back(make_req(CMD_READ, 200, 5, 1, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 5, 200, 0, 0, 0));
		req_queue.push_back(make_req(CMD_CLEAR, 12, 10, 1, 0, 0));
		req_queue.push_back(make_req(CMD_READ, 12, 10, 0, 0, 0));

		lx = 10;
		ly = 10;
		lh = 1'b1;
		cnt = 0;
		while (cnt < RANDOM_REQS) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				lx = pick_coord();
				ly = pick_coord();
				lh = $urandom_range(1);
				req_queue.push_back(make_req(CMD_UPDATE, lx, ly, lh, pick_dist(), pick_dist()));
				cnt++;
			end else if (kind < 90) begin
				kind = $urandom_range(99);
				if (kind < 60) begin
					x = clip_byte(lx + (lh ? $urandom_range(24) - 12 : $urandom_range(2) - 1));
					y = clip_byte(ly + (lh ? $urandom_range(2) - 1 : $urandom_range(24) - 12));
				end else if (kind < 90) begin
					x = $urandom_range(MAP_SIDE - 1);
					y = $urandom_range(MAP_SIDE - 1);
				end else begin
					x = $urandom_range(255);
					y = $urandom_range(255);
				end
				req_queue.push_back(make_req(CMD_READ, x, y, $urandom_range(1),
					$urandom_range(255), $urandom_range(255)));
				cnt++;
			end else if (kind < 95) begin
				req_queue.push_back(make_req(CMD_CLEAR, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(255), $urandom_range(255)));
				cnt++;
			end else begin
				req_queue.push_back(make_req(CMD_UNUSED, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(255), $urandom_range(255)));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() > 0 || s_tvalid || cell_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (cell_expect.size() > 0) begin
			$display("%0d reads never answered", cell_expect.size());
			errors++;
		end

		$display("covered %0d updates, %0d reads (%0d results checked), %0d clears, %0d unused codes",
			n_update, n_read, n_checked, n_clear, n_ignored);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
